>>> hw/rtl/itu_pkg.sv
// Shared types, constants and calendar helpers for the IRIG-B time to UTC converter.
// Used by itu_front, itu_queue, itu_back and irig_b_time_to_utc; depends on nothing.
package itu_pkg;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Calendar and time constants
  localparam int YEAR_BASE      = 2000;
  localparam int YEAR_NO_LEAP   = 2100;
  localparam int YEAR_FIRST     = 1999;
  localparam int DAYS_TO_FIRST  = 10592;  // days from 1970-01-01 to 1999-01-01
  localparam int CENTURY_OFFSET = 101;    // year offset from 1999 of the last year before 2101
  localparam int DAYS_PER_YEAR  = 365;
  localparam int SECS_PER_DAY   = 86400;
  localparam int SECS_PER_HOUR  = 3600;
  localparam int SECS_PER_MIN   = 60;
  localparam int MINS_PER_HOUR  = 60;

  // Result status codes, checked in this order
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TIME_BAD = 3'd1,
    ST_DATE_BAD = 3'd2,
    ST_SBS_BAD  = 3'd3,
    ST_MISMATCH = 3'd4
  } status_t;

  // Decoded snapshot passed from front to back
  typedef struct packed {
    logic [6:0]  sec;
    logic [6:0]  min;
    logic [5:0]  hour;
    logic [8:0]  doy;
    logic [7:0]  year_off;   // years since 2000
    logic        tod_ok;
    logic        date_ok;
    logic        sbs_ok;
    logic [16:0] sbs;
  } dec_t;

  // Gregorian leap year, valid for the years this block can see (1999 to 2166)
  function automatic logic is_leap(input logic [11:0] year);
    is_leap = (year[1:0] == 2'b00) && (year != 12'(YEAR_NO_LEAP));
  endfunction

  // Day of year at the end of the month before month index idx
  function automatic logic [8:0] month_start(input logic lp, input logic [3:0] idx);
    logic [8:0] base;
    base = 9'd0;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd365;
    endcase
    if (lp && (idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    month_start = base;
  endfunction

endpackage

>>> hw/rtl/itu_front.sv
// Front end: accepts input beats, decodes the BCD fields and holds them in a register.
// Depends on itu_pkg for the decoded snapshot type.
module itu_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_sec_raw,
  input  logic [7:0]     in_min_raw,
  input  logic [6:0]     in_hour_raw,
  input  logic           in_tod_valid,
  input  logic [10:0]    in_day_raw,
  input  logic [8:0]     in_year_raw,
  input  logic           in_date_valid,
  input  logic [16:0]    in_sbs_count,
  input  logic           in_sbs_valid,
  output logic           dec_valid,
  input  logic           dec_ready,
  output itu_pkg::dec_t  dec_data
);

  logic          valid_r;
  itu_pkg::dec_t data_r;
  itu_pkg::dec_t data_nxt;

  // Take a new beat whenever the held one is empty or moving on
  assign in_ready = !valid_r || dec_ready;

  // Decode BCD digits; bit 4 of each field carries no weight
  always_comb begin
    data_nxt.sec      = 7'(in_sec_raw[3:0]) + 7'(in_sec_raw[7:5]) * 7'd10;
    data_nxt.min      = 7'(in_min_raw[3:0]) + 7'(in_min_raw[7:5]) * 7'd10;
    data_nxt.hour     = 6'(in_hour_raw[3:0]) + 6'(in_hour_raw[6:5]) * 6'd10;
    data_nxt.doy      = 9'(in_day_raw[3:0]) + 9'(in_day_raw[8:5]) * 9'd10
                      + 9'(in_day_raw[10:9]) * 9'd100;
    data_nxt.year_off = 8'(in_year_raw[3:0]) + 8'(in_year_raw[8:5]) * 8'd10;
    data_nxt.tod_ok   = in_tod_valid;
    data_nxt.date_ok  = in_date_valid;
    data_nxt.sbs_ok   = in_sbs_valid;
    data_nxt.sbs      = in_sbs_count;
  end

  // Hold the decoded beat until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dec_valid = valid_r;
  assign dec_data  = data_r;

endmodule

>>> hw/rtl/itu_queue.sv
// Short queue of decoded snapshots between front and back end.
// Depends on itu_pkg for the decoded snapshot type.
module itu_queue #(
  parameter int DEPTH = itu_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  itu_pkg::dec_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output itu_pkg::dec_t  pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  itu_pkg::dec_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_nxt;
  logic          push;
  logic          pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/itu_back.sv
// Back end: four-stage pipeline that normalises the date, checks SBS against the
// BCD time and forms the UTC seconds; the last stage is the output register. Uses itu_pkg.
module itu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                dec_valid,
  output logic                dec_ready,
  input  itu_pkg::dec_t       dec_data,
  output logic                out_valid,
  input  logic                out_ready,
  output itu_pkg::status_t    res_status,
  output logic [32:0]         res_utc,
  output logic [11:0]         res_year,
  output logic [3:0]          res_month,
  output logic [4:0]          res_day,
  output logic [5:0]          res_hour,
  output logic [6:0]          res_minute,
  output logic [6:0]          res_second
);

  typedef struct packed {
    itu_pkg::status_t status;
    logic [11:0]      year;
    logic [8:0]       doy;
    logic [5:0]       hour;
    logic [6:0]       min;
    logic [6:0]       sec;
    logic [17:0]      tod_secs;
  } s1_t;

  typedef struct packed {
    itu_pkg::status_t status;
    logic [11:0]      year;
    logic [3:0]       month;
    logic [4:0]       mday;
    logic [5:0]       hour;
    logic [6:0]       min;
    logic [6:0]       sec;
    logic [17:0]      tod_secs;
    logic [16:0]      days;
  } s2_t;

  typedef struct packed {
    itu_pkg::status_t status;
    logic [11:0]      year;
    logic [3:0]       month;
    logic [4:0]       mday;
    logic [5:0]       hour;
    logic [6:0]       min;
    logic [6:0]       sec;
    logic [17:0]      tod_secs;
    logic [32:0]      day_secs;
  } s3_t;

  typedef struct packed {
    itu_pkg::status_t status;
    logic [32:0]      utc;
    logic [11:0]      year;
    logic [3:0]       month;
    logic [4:0]       mday;
    logic [5:0]       hour;
    logic [6:0]       min;
    logic [6:0]       sec;
  } s4_t;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;

  // Each stage moves when the one after it is empty or moving
  assign en4       = !v4_r || out_ready;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign dec_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= dec_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Stage 1: normalise day of year, form seconds of day, set status
  always_comb begin
    logic [11:0] year;
    logic        leap_cur;
    logic        leap_prev;
    logic [8:0]  year_len;
    logic        match;
    year      = 12'(itu_pkg::YEAR_BASE) + 12'(dec_data.year_off);
    leap_cur  = itu_pkg::is_leap(year);
    leap_prev = itu_pkg::is_leap(year - 12'd1);
    year_len  = 9'(itu_pkg::DAYS_PER_YEAR) + 9'(leap_cur);

    s1_nxt.year = year;
    s1_nxt.doy  = dec_data.doy;
    if (dec_data.doy == 9'd0) begin
      s1_nxt.year = year - 12'd1;
      s1_nxt.doy  = 9'(itu_pkg::DAYS_PER_YEAR) + 9'(leap_prev);
    end else if (dec_data.doy > year_len) begin
      s1_nxt.year = year + 12'd1;
      s1_nxt.doy  = dec_data.doy - year_len;
    end

    s1_nxt.hour     = dec_data.hour;
    s1_nxt.min      = dec_data.min;
    s1_nxt.sec      = dec_data.sec;
    s1_nxt.tod_secs = 18'(dec_data.hour) * 18'(itu_pkg::SECS_PER_HOUR)
                    + 18'(dec_data.min) * 18'(itu_pkg::SECS_PER_MIN)
                    + 18'(dec_data.sec);

    // SBS splits to the BCD time only if both fields are in range and totals agree
    match = (dec_data.sec < 7'(itu_pkg::SECS_PER_MIN))
         && (dec_data.min < 7'(itu_pkg::MINS_PER_HOUR))
         && (18'(dec_data.sbs) == s1_nxt.tod_secs);

    if (!dec_data.tod_ok) begin
      s1_nxt.status = itu_pkg::ST_TIME_BAD;
    end else if (!dec_data.date_ok) begin
      s1_nxt.status = itu_pkg::ST_DATE_BAD;
    end else if (!dec_data.sbs_ok) begin
      s1_nxt.status = itu_pkg::ST_SBS_BAD;
    end else if (!match) begin
      s1_nxt.status = itu_pkg::ST_MISMATCH;
    end else begin
      s1_nxt.status = itu_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && dec_valid) begin
      s1_r <= s1_nxt;
    end
  end

  // Stage 2: month search, day of month, days since the epoch
  always_comb begin
    logic       lp;
    logic [3:0] month;
    logic [8:0] mbase;
    logic [7:0] n;
    lp    = itu_pkg::is_leap(s1_r.year);
    month = 4'd1;
    for (int m = 1; m < 12; m++) begin
      if (s1_r.doy > itu_pkg::month_start(lp, 4'(m))) begin
        month = month + 4'd1;
      end
    end
    mbase = itu_pkg::month_start(lp, month - 4'd1);
    n     = 8'(s1_r.year - 12'(itu_pkg::YEAR_FIRST));

    s2_nxt.status   = s1_r.status;
    s2_nxt.year     = s1_r.year;
    s2_nxt.month    = month;
    s2_nxt.mday     = 5'(s1_r.doy - mbase);
    s2_nxt.hour     = s1_r.hour;
    s2_nxt.min      = s1_r.min;
    s2_nxt.sec      = s1_r.sec;
    s2_nxt.tod_secs = s1_r.tod_secs;
    s2_nxt.days     = 17'(itu_pkg::DAYS_TO_FIRST)
                    + 17'(n) * 17'(itu_pkg::DAYS_PER_YEAR)
                    + 17'((n + 8'd2) >> 2)
                    - 17'(n > 8'(itu_pkg::CENTURY_OFFSET))
                    + 17'(s1_r.doy) - 17'd1;
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      s2_r <= s2_nxt;
    end
  end

  // Stage 3: scale days to seconds
  always_comb begin
    logic [33:0] prod;
    prod            = 34'(s2_r.days) * 34'(itu_pkg::SECS_PER_DAY);
    s3_nxt.status   = s2_r.status;
    s3_nxt.year     = s2_r.year;
    s3_nxt.month    = s2_r.month;
    s3_nxt.mday     = s2_r.mday;
    s3_nxt.hour     = s2_r.hour;
    s3_nxt.min      = s2_r.min;
    s3_nxt.sec      = s2_r.sec;
    s3_nxt.tod_secs = s2_r.tod_secs;
    s3_nxt.day_secs = prod[32:0];
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      s3_r <= s3_nxt;
    end
  end

  // Stage 4: add seconds of day; drop the count on any error
  always_comb begin
    s4_nxt.status = s3_r.status;
    s4_nxt.utc    = (s3_r.status == itu_pkg::ST_OK)
                  ? s3_r.day_secs + 33'(s3_r.tod_secs) : 33'd0;
    s4_nxt.year   = s3_r.year;
    s4_nxt.month  = s3_r.month;
    s4_nxt.mday   = s3_r.mday;
    s4_nxt.hour   = s3_r.hour;
    s4_nxt.min    = s3_r.min;
    s4_nxt.sec    = s3_r.sec;
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      s4_r <= s4_nxt;
    end
  end

  assign out_valid  = v4_r;
  assign res_status = s4_r.status;
  assign res_utc    = s4_r.utc;
  assign res_year   = s4_r.year;
  assign res_month  = s4_r.month;
  assign res_day    = s4_r.mday;
  assign res_hour   = s4_r.hour;
  assign res_minute = s4_r.min;
  assign res_second = s4_r.sec;

endmodule

>>> hw/rtl/irig_b_time_to_utc.sv
// IRIG-B time snapshot to UTC converter, top level.
// Instantiates itu_front, itu_queue and itu_back; uses itu_pkg.
//
// Usage:
//   The in_ channel takes one IRIG-B snapshot per beat: BCD time of day, BCD day
//   of year and year, straight binary seconds, and a valid flag for each field.
//   The out_ channel returns one result per snapshot, in order: a status code,
//   the UTC seconds since 1970 (zero unless status is ok) and the decoded
//   calendar date and time.
//   Throughput is one snapshot per clock cycle while out_ready stays high. An
//   accepted beat passes through the front decode register, the queue, and
//   three pipeline stages plus the output register in the back end, where the
//   days-to-seconds multiply and the calendar search each take a stage of
//   their own.
//   When out_ready is low the back end fills its empty stages, then the queue
//   of QUEUE_DEPTH snapshots absorbs further beats before in_ready drops.
//   Synchronous reset empties the front register, queue and pipeline; no
//   result is pending after reset.
module irig_b_time_to_utc #(
  parameter int QUEUE_DEPTH = itu_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_sec_raw,
  input  logic [7:0]  in_min_raw,
  input  logic [6:0]  in_hour_raw,
  input  logic        in_tod_valid,
  input  logic [10:0] in_day_raw,
  input  logic [8:0]  in_year_raw,
  input  logic        in_date_valid,
  input  logic [16:0] in_sbs_count,
  input  logic        in_sbs_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [32:0] out_utc_seconds,
  output logic [11:0] out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic [5:0]  out_hour_out,
  output logic [6:0]  out_minute_out,
  output logic [6:0]  out_second_out
);

  logic             fr_valid;
  logic             fr_ready;
  itu_pkg::dec_t    fr_data;
  logic             q_valid;
  logic             q_ready;
  itu_pkg::dec_t    q_data;
  itu_pkg::status_t res_status;

  // Accept and decode
  itu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sec_raw    (in_sec_raw),
    .in_min_raw    (in_min_raw),
    .in_hour_raw   (in_hour_raw),
    .in_tod_valid  (in_tod_valid),
    .in_day_raw    (in_day_raw),
    .in_year_raw   (in_year_raw),
    .in_date_valid (in_date_valid),
    .in_sbs_count  (in_sbs_count),
    .in_sbs_valid  (in_sbs_valid),
    .dec_valid     (fr_valid),
    .dec_ready     (fr_ready),
    .dec_data      (fr_data)
  );

  // Buffer decoded beats
  itu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // Convert and deliver
  itu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dec_valid  (q_valid),
    .dec_ready  (q_ready),
    .dec_data   (q_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res_status (res_status),
    .res_utc    (out_utc_seconds),
    .res_year   (out_year_out),
    .res_month  (out_month_out),
    .res_day    (out_day_out),
    .res_hour   (out_hour_out),
    .res_minute (out_minute_out),
    .res_second (out_second_out)
  );

  assign out_status = res_status;

endmodule
